>>> src/ddo_pkg.sv
// Shared types, constants and tables for the differential-drive odometry block.
`timescale 1ns / 1ps
`default_nettype none
package ddo_pkg;

	localparam logic [31:0] KANG        = 32'd2867080570;
	localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
	localparam logic [19:0] USEC_DIV    = 20'd1000000;
	localparam logic [18:0] USEC_HALF   = 19'd500000;
	localparam logic [31:0] USEC_RECIP  = 32'd2251799813;
	localparam logic [63:0] USEC_CLAMP  = 64'd4294967297000000;
	localparam logic [5:0]  DIV_LAST_STEP = 6'd4;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SPEED,
		OP_YAW,
		OP_PROD,
		OP_ANGLE,
		OP_DIV_STEP,
		OP_CORDIC_INIT,
		OP_CORDIC_STEP,
		OP_PROJ_X,
		OP_PROJ_Y,
		OP_COMMIT,
		OP_RESTART
	} ddo_op_t;

	typedef struct packed {
		ddo_op_t    op;
		logic [5:0] step;
	} ddo_cmd_t;

	localparam logic [0:0] REG_WHEEL_RADIUS    = 1'd0;
	localparam logic [0:0] REG_INV_AXLE_LENGTH = 1'd1;

	function automatic logic [31:0] atan_unit(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/ddo_ctrl.sv
// Sequencer that steps the odometry datapath through one transfer.
`timescale 1ns / 1ps
`default_nettype none
module ddo_ctrl #(
	parameter int CORDIC_STEPS = 20
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_fire,
	input  wire                  restart_in,
	input  wire                  out_free,
	output ddo_pkg::ddo_cmd_t    cmd,
	output logic                 busy
);
	import ddo_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SPEED, S_YAW, S_PROD, S_ANGLE, S_DIV, S_CINIT, S_CSTEP,
		S_PX, S_PY, S_WAIT
	} state_t;

	state_t     state_q;
	logic [5:0] step_q;
	logic       rst_item_q;

	always_comb begin
		cmd.step = step_q;
		unique case (state_q)
			S_IDLE:  cmd.op = in_fire ? OP_LOAD : OP_NONE;
			S_SPEED: cmd.op = OP_SPEED;
			S_YAW:   cmd.op = OP_YAW;
			S_PROD:  cmd.op = OP_PROD;
			S_ANGLE: cmd.op = OP_ANGLE;
			S_DIV:   cmd.op = OP_DIV_STEP;
			S_CINIT: cmd.op = OP_CORDIC_INIT;
			S_CSTEP: cmd.op = OP_CORDIC_STEP;
			S_PX:    cmd.op = OP_PROJ_X;
			S_PY:    cmd.op = OP_PROJ_Y;
			S_WAIT:  cmd.op = out_free ? (rst_item_q ? OP_RESTART : OP_COMMIT) : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= '0;
			rst_item_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					rst_item_q <= restart_in;
					state_q    <= restart_in ? S_WAIT : S_SPEED;
				end
				S_SPEED: state_q <= S_YAW;
				S_YAW:   state_q <= S_PROD;
				S_PROD:  state_q <= S_ANGLE;
				S_ANGLE: begin
					state_q <= S_DIV;
					step_q  <= '0;
				end
				S_DIV: begin
					if (step_q == DIV_LAST_STEP) begin
						state_q <= S_CINIT;
						step_q  <= '0;
					end else step_q <= step_q + 6'd1;
				end
				S_CINIT: state_q <= S_CSTEP;
				S_CSTEP: begin
					if (step_q == 6'(CORDIC_STEPS - 1)) begin
						state_q <= S_PX;
						step_q  <= '0;
					end else step_q <= step_q + 6'd1;
				end
				S_PX: state_q <= S_PY;
				S_PY: state_q <= S_WAIT;
				S_WAIT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> src/ddo_datapath.sv
// Arithmetic datapath: speeds, time scaling, CORDIC and pose registers.
`timescale 1ns / 1ps
`default_nettype none
module ddo_datapath #(
	parameter int TIME_BITS    = 48
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  ddo_pkg::ddo_cmd_t           cmd,
	input  wire         [19:0]          wheel_radius,
	input  wire         [23:0]          inv_axle_length,
	input  wire  signed [23:0]          left_wheel_speed,
	input  wire  signed [23:0]          right_wheel_speed,
	input  wire         [TIME_BITS-1:0] sample_time,
	output logic signed [31:0]          position_x,
	output logic signed [31:0]          position_y,
	output logic        [31:0]          heading,
	output logic signed [31:0]          linear_speed,
	output logic signed [31:0]          yaw_rate
);
	import ddo_pkg::*;

	logic signed [31:0]          pose_x_q, pose_y_q, v_q, w_q, yawt_q;
	logic        [31:0]          heading_q, full_q, half_q;
	logic        [TIME_BITS-1:0] last_time_q;
	logic signed [24:0]          l_q, r_q;
	logic        [31:0]          dt_q;
	logic        [63:0]          pv_q;
	logic        [63:0]          pw_q;
	logic        [63:0]          alo_q;
	logic        [32:0]          quo_q;
	logic        [22:0]          rem_q;
	logic                        big_q;
	logic signed [33:0]          cx_q, cy_q, cz_q;
	logic        [1:0]           quad_q;
	logic signed [33:0]          d_q;

	logic        [TIME_BITS-1:0] dt_raw;
	logic signed [45:0]          rprod;
	logic signed [63:0]          tprod;
	logic        [95:0]          ang_full;
	logic        [31:0]          full_r, half_r;
	logic signed [33:0]          xs, ys;
	logic        [31:0]          z0;
	logic signed [33:0]          cs_c, cs_s;
	logic signed [67:0]          pr;
	logic signed [36:0]          psum;
	logic        [31:0]          vmag, wmag;

	assign dt_raw = sample_time - last_time_q;
	assign vmag   = v_q[31] ? 32'(-v_q) : 32'(v_q);
	assign wmag   = w_q[31] ? 32'(-w_q) : 32'(w_q);
	assign xs     = cx_q >>> cmd.step;
	assign ys     = cy_q >>> cmd.step;
	assign z0     = heading_q + half_q + 32'h20000000;
	assign ang_full = {32'd0, alo_q} + {64'(pw_q[63:32] * KANG), 32'd0};
	assign full_r = 32'((ang_full + (96'd1 << 37)) >> 38);
	assign half_r = 32'((ang_full + (96'd1 << 38)) >> 39);

	always_comb begin
		rprod = '0;
		tprod = '0;
		unique case (cmd.op)
			OP_SPEED: rprod = $signed({1'b0, wheel_radius}) * (l_q + r_q);
			OP_YAW:   rprod = $signed({1'b0, wheel_radius}) * (r_q - l_q);
			OP_PROD:  tprod = yawt_q * $signed({1'b0, inv_axle_length});
			default: ;
		endcase
		unique case (quad_q)
			2'd0:    begin cs_c = cx_q;  cs_s = cy_q;  end
			2'd1:    begin cs_c = -cy_q; cs_s = cx_q;  end
			2'd2:    begin cs_c = -cx_q; cs_s = -cy_q; end
			default: begin cs_c = cy_q;  cs_s = -cx_q; end
		endcase
		pr   = d_q * ((cmd.op == OP_PROJ_X) ? cs_c : cs_s);
		psum = ((cmd.op == OP_PROJ_X) ? 37'(pose_x_q) : 37'(pose_y_q)) +
			37'((pr + 68'sh20000000) >>> 30);
	end

	function automatic logic signed [31:0] sat(input logic signed [47:0] a);
		if (a > 48'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (a < -48'sh80000000) return 32'sh80000000;
		return a[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			heading_q   <= '0;
			last_time_q <= '0;
			position_x  <= '0;
			position_y  <= '0;
			heading     <= '0;
			linear_speed <= '0;
			yaw_rate    <= '0;
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					l_q  <= 25'(left_wheel_speed);
					r_q  <= 25'(right_wheel_speed);
					dt_q <= (dt_raw > TIME_BITS'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : dt_raw[31:0];
					last_time_q <= sample_time;
				end
				OP_SPEED: v_q <= sat(48'((rprod + 46'sd65536) >>> 17));
				OP_YAW:   yawt_q <= 32'((rprod + 46'sd32768) >>> 16);
				OP_PROD:  w_q <= sat(48'((tprod + 64'sd32768) >>> 16));
				OP_ANGLE: begin
					pv_q  <= 64'(vmag * dt_q) + 64'(USEC_HALF);
					pw_q  <= 64'(wmag * dt_q);
				end
				OP_DIV_STEP: begin
					if (cmd.step == 6'd0) begin
						alo_q <= 64'(pw_q[31:0] * KANG);
						quo_q <= 33'(64'(pv_q[51:20] * USEC_RECIP) >> 31);
						big_q <= (pv_q >= USEC_CLAMP);
					end else if (cmd.step == 6'd1) begin
						full_q <= w_q[31] ? 32'd0 - full_r : full_r;
						half_q <= w_q[31] ? 32'd0 - half_r : half_r;
						rem_q  <= 23'(pv_q - 64'(quo_q * USEC_DIV));
					end else if (rem_q >= 23'(USEC_DIV)) begin
						rem_q <= rem_q - 23'(USEC_DIV);
						quo_q <= quo_q + 33'd1;
					end
				end
				OP_CORDIC_INIT: begin
					quad_q <= z0[31:30];
					cz_q <= $signed({4'd0, z0[29:0]}) - 34'sh20000000;
					cx_q <= $signed(CORDIC_GAIN);
					cy_q <= '0;
					if (big_q) d_q <= v_q[31] ? -34'sh100000000 : 34'sh100000000;
					else d_q <= v_q[31] ? -$signed(34'(quo_q)) : $signed(34'(quo_q));
				end
				OP_CORDIC_STEP: begin
					if (cz_q >= 0) begin
						cx_q <= cx_q - ys;
						cy_q <= cy_q + xs;
						cz_q <= cz_q - $signed({2'd0, atan_unit(cmd.step[4:0])});
					end else begin
						cx_q <= cx_q + ys;
						cy_q <= cy_q - xs;
						cz_q <= cz_q + $signed({2'd0, atan_unit(cmd.step[4:0])});
					end
				end
				OP_PROJ_X: pose_x_q <= sat(48'(psum));
				OP_PROJ_Y: pose_y_q <= sat(48'(psum));
				OP_COMMIT: begin
					heading_q    <= heading_q + full_q;
					position_x   <= pose_x_q;
					position_y   <= pose_y_q;
					heading      <= heading_q + full_q;
					linear_speed <= v_q;
					yaw_rate     <= w_q;
				end
				OP_RESTART: begin
					pose_x_q     <= '0;
					pose_y_q     <= '0;
					heading_q    <= '0;
					last_time_q  <= sample_time;
					position_x   <= '0;
					position_y   <= '0;
					heading      <= '0;
					linear_speed <= '0;
					yaw_rate     <= '0;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> src/diff_drive_odometry.sv
// Top level of the differential-drive odometry block.
`timescale 1ns / 1ps
`default_nettype none
// A normal sample passes, after its transfer, through the speed and scaling products,
// the travel quotient by reciprocal multiplication with up to three correction steps
// and the heading products, a CORDIC setup step, CORDIC_STEPS rotations of one
// shared CORDIC stage, the X and Y projections and the result load. A restart goes
// from its transfer straight to the result load. The sequencer handles one sample
// at a time and is ready again in the cycle after the result is loaded; a result
// that is not taken holds the next load back.
module diff_drive_odometry #(
	parameter int CORDIC_STEPS = 20,
	parameter int TIME_BITS    = 48
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire         [0:0]           cfg_index,
	input  wire         [23:0]          cfg_data,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire  signed [23:0]          left_wheel_speed,
	input  wire  signed [23:0]          right_wheel_speed,
	input  wire         [TIME_BITS-1:0] sample_time,
	input  wire                         restart,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic signed [31:0]          position_x,
	output logic signed [31:0]          position_y,
	output logic        [31:0]          heading,
	output logic signed [31:0]          linear_speed,
	output logic signed [31:0]          yaw_rate
);
	import ddo_pkg::*;

	logic [19:0] wheel_radius_q;
	logic [23:0] inv_axle_length_q;
	ddo_cmd_t    cmd;
	logic        busy, in_fire, out_free;

	// Sample fields are captured at the transfer and held here for the later steps.
	logic signed [23:0]          l_hold_q, r_hold_q;
	logic        [TIME_BITS-1:0] t_hold_q;

	assign in_ready = !busy;
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_radius_q    <= '0;
			inv_axle_length_q <= '0;
			out_valid         <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WHEEL_RADIUS:    wheel_radius_q    <= cfg_data[19:0];
					REG_INV_AXLE_LENGTH: inv_axle_length_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == OP_COMMIT || cmd.op == OP_RESTART) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			l_hold_q <= left_wheel_speed;
			r_hold_q <= right_wheel_speed;
			t_hold_q <= sample_time;
		end
	end

	ddo_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .restart_in(restart),
		.out_free(out_free), .cmd(cmd), .busy(busy)
	);

	ddo_datapath #(.TIME_BITS(TIME_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.wheel_radius(wheel_radius_q), .inv_axle_length(inv_axle_length_q),
		.left_wheel_speed(in_fire ? left_wheel_speed : l_hold_q),
		.right_wheel_speed(in_fire ? right_wheel_speed : r_hold_q),
		.sample_time(in_fire ? sample_time : t_hold_q),
		.position_x(position_x), .position_y(position_y), .heading(heading),
		.linear_speed(linear_speed), .yaw_rate(yaw_rate)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready) else $error("input accepted while busy");
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(busy)) else $error("result without work");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(position_x) && $stable(heading)))
		else $error("result changed while stalled");
endmodule
`default_nettype wire
